@@ design/tsd_pkg.sv @@
// Package for the TLV stream decoder: codes, register indexes and shared types.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

  // Entry kinds
  localparam logic [2:0] KIND_BUFFER   = 3'd0;
  localparam logic [2:0] KIND_UNSIGNED = 3'd1;
  localparam logic [2:0] KIND_ETHERNET = 3'd2;
  localparam logic [2:0] KIND_IP       = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;
  localparam logic [2:0] KIND_OTHER    = 3'd5;

  // Entry status
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_END       = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
  localparam logic [1:0] STATUS_BAD_SIZE  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_BUFFER     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_UNSIGNED   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_ETHERNET   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_IP_ADDRESS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_END_MARKER = 3'd4;

  // Register reset values
  localparam logic [31:0] RST_CODE_BUFFER     = 32'd1;
  localparam logic [31:0] RST_CODE_UNSIGNED   = 32'd2;
  localparam logic [31:0] RST_CODE_ETHERNET   = 32'd3;
  localparam logic [31:0] RST_CODE_IP_ADDRESS = 32'd4;
  localparam logic [31:0] RST_CODE_END_MARKER = 32'd100;

  // Header is a 4-byte type then a 4-byte length
  localparam logic [2:0] HDR_LAST_BYTE = 3'd7;

  typedef struct packed {
    logic [31:0] code_buffer;
    logic [31:0] code_unsigned;
    logic [31:0] code_ethernet;
    logic [31:0] code_ip_address;
    logic [31:0] code_end_marker;
  } codes_t;

  typedef struct packed {
    logic        value_byte_valid;
    logic [7:0]  value_byte;
    logic        entry_done;
    logic [1:0]  entry_status;
    logic [2:0]  entry_kind;
    logic [31:0] type_code;
    logic [31:0] value_length;
    logic [63:0] decoded_value;
  } result_t;

endpackage

`default_nettype wire

@@ design/tsd_in_if.sv @@
// Input byte channel of the TLV stream decoder.
`timescale 1ns / 1ps
`default_nettype none

interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_last;

  modport source (output valid, output in_byte, output buffer_last, input ready);
  modport sink   (input valid, input in_byte, input buffer_last, output ready);
endinterface

`default_nettype wire

@@ design/tsd_out_if.sv @@
// Result channel of the TLV stream decoder.
`timescale 1ns / 1ps
`default_nettype none

interface tsd_out_if;
  logic        valid;
  logic        ready;
  logic        value_byte_valid;
  logic [7:0]  value_byte;
  logic        entry_done;
  logic [1:0]  entry_status;
  logic [2:0]  entry_kind;
  logic [31:0] type_code;
  logic [31:0] value_length;
  logic [63:0] decoded_value;

  modport source (output valid, output value_byte_valid, output value_byte,
                  output entry_done, output entry_status, output entry_kind,
                  output type_code, output value_length, output decoded_value,
                  input ready);
  modport sink   (input valid, input value_byte_valid, input value_byte,
                  input entry_done, input entry_status, input entry_kind,
                  input type_code, input value_length, input decoded_value,
                  output ready);
endinterface

`default_nettype wire

@@ design/tsd_cfg_if.sv @@
// Configuration write channel of the TLV stream decoder.
`timescale 1ns / 1ps
`default_nettype none

interface tsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/tsd_cfg_regs.sv @@
// Type code registers of the TLV stream decoder.
`timescale 1ns / 1ps
`default_nettype none

module tsd_cfg_regs
  import tsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  tsd_cfg_if.sink    cfg,
  output codes_t     codes
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.code_buffer     <= RST_CODE_BUFFER;
      codes.code_unsigned   <= RST_CODE_UNSIGNED;
      codes.code_ethernet   <= RST_CODE_ETHERNET;
      codes.code_ip_address <= RST_CODE_IP_ADDRESS;
      codes.code_end_marker <= RST_CODE_END_MARKER;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CODE_BUFFER:     codes.code_buffer     <= cfg.data;
        REG_CODE_UNSIGNED:   codes.code_unsigned   <= cfg.data;
        REG_CODE_ETHERNET:   codes.code_ethernet   <= cfg.data;
        REG_CODE_IP_ADDRESS: codes.code_ip_address <= cfg.data;
        REG_CODE_END_MARKER: codes.code_end_marker <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/tsd_parser.sv @@
// TLV header/value parser: state registers and per-byte result logic.
`timescale 1ns / 1ps
`default_nettype none

module tsd_parser
  import tsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [7:0]  in_byte,
  input  wire logic        buffer_last,
  input  wire codes_t      codes,
  output logic             has_result,
  output result_t          result
);

  logic        in_value_phase, in_value_phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [31:0] type_reg, type_reg_next;
  logic [31:0] length_reg, length_reg_next;
  logic [31:0] remaining, remaining_next;
  logic [63:0] value_accum, value_accum_next;

  function automatic logic [2:0] classify(logic [31:0] t, codes_t c);
    logic [2:0] k;
    if (t == c.code_end_marker)      k = KIND_END;
    else if (t == c.code_buffer)     k = KIND_BUFFER;
    else if (t == c.code_unsigned)   k = KIND_UNSIGNED;
    else if (t == c.code_ethernet)   k = KIND_ETHERNET;
    else if (t == c.code_ip_address) k = KIND_IP;
    else                             k = KIND_OTHER;
    return k;
  endfunction

  // Entry report fields; value byte fields are left clear
  function automatic result_t finish(logic truncated, logic header_cut,
                                     logic [31:0] t, logic [31:0] n,
                                     logic [63:0] acc, codes_t c);
    result_t r;
    r = '0;
    r.entry_done   = 1'b1;
    r.entry_kind   = header_cut ? KIND_OTHER : classify(t, c);
    r.entry_status = STATUS_OK;
    r.type_code    = t;
    r.value_length = n;
    if (truncated) begin
      r.entry_status = STATUS_TRUNCATED;
    end else begin
      case (r.entry_kind)
        KIND_END: begin
          r.entry_status = STATUS_END;
        end
        KIND_UNSIGNED: begin
          if (n == 32'd1 || n == 32'd2 || n == 32'd4 || n == 32'd8)
            r.decoded_value = acc;
          else
            r.entry_status = STATUS_BAD_SIZE;
        end
        KIND_ETHERNET: begin
          if (n == 32'd6) r.decoded_value = {16'd0, acc[47:0]};
          else            r.entry_status = STATUS_BAD_SIZE;
        end
        KIND_IP: begin
          if (n == 32'd4)       r.decoded_value = {32'd0, acc[31:0]};
          else if (n != 32'd16) r.entry_status = STATUS_BAD_SIZE;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always_comb begin
    in_value_phase_next = in_value_phase;
    header_count_next   = header_count;
    type_reg_next       = type_reg;
    length_reg_next     = length_reg;
    remaining_next      = remaining;
    value_accum_next    = value_accum;
    has_result          = 1'b0;
    result              = '0;

    if (in_value_phase) begin
      value_accum_next = {value_accum[55:0], in_byte};
      remaining_next   = remaining - 32'd1;
      if (remaining == 32'd1) begin
        result = finish(1'b0, 1'b0, type_reg, length_reg, value_accum_next, codes);
        in_value_phase_next = 1'b0;
        header_count_next   = '0;
      end else if (buffer_last) begin
        result = finish(1'b1, 1'b0, type_reg, length_reg, value_accum_next, codes);
        in_value_phase_next = 1'b0;
        header_count_next   = '0;
      end
      has_result              = 1'b1;
      result.value_byte_valid = 1'b1;
      result.value_byte       = in_byte;
    end else begin
      if (header_count == '0) begin
        type_reg_next   = '0;
        length_reg_next = '0;
      end
      if (!header_count[2]) type_reg_next   = {type_reg_next[23:0], in_byte};
      else                  length_reg_next = {length_reg_next[23:0], in_byte};
      header_count_next = header_count + 3'd1;

      if (header_count == HDR_LAST_BYTE) begin
        value_accum_next = '0;
        if (length_reg_next == '0) begin
          has_result = 1'b1;
          result = finish(1'b0, 1'b0, type_reg_next, length_reg_next, '0, codes);
        end else if (buffer_last) begin
          has_result = 1'b1;
          result = finish(1'b1, 1'b0, type_reg_next, length_reg_next, '0, codes);
        end else begin
          in_value_phase_next = 1'b1;
          remaining_next      = length_reg_next;
        end
      end else if (buffer_last) begin
        // cut inside the header: partial fields, kind other
        has_result        = 1'b1;
        value_accum_next  = '0;
        header_count_next = '0;
        result = finish(1'b1, 1'b1, type_reg_next, length_reg_next, '0, codes);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value_phase <= 1'b0;
      header_count   <= '0;
    end else if (fire) begin
      in_value_phase <= in_value_phase_next;
      header_count   <= header_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      type_reg    <= type_reg_next;
      length_reg  <= length_reg_next;
      remaining   <= remaining_next;
      value_accum <= value_accum_next;
    end
  end

endmodule

`default_nettype wire

@@ design/tsd_out_reg.sv @@
// Result register of the TLV stream decoder, holding one request for the sink.
`timescale 1ns / 1ps
`default_nettype none

module tsd_out_reg
  import tsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire result_t  result_in,
  output logic          space,
  tsd_out_if.source     result
);

  logic    valid;
  result_t data;

  // free now, or freed by the sink this cycle
  assign space = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result_in;
    end
  end

  assign result.valid            = valid;
  assign result.value_byte_valid = data.value_byte_valid;
  assign result.value_byte       = data.value_byte;
  assign result.entry_done       = data.entry_done;
  assign result.entry_status     = data.entry_status;
  assign result.entry_kind       = data.entry_kind;
  assign result.type_code        = data.type_code;
  assign result.value_length     = data.value_length;
  assign result.decoded_value    = data.decoded_value;

endmodule

`default_nettype wire

@@ design/tlv_stream_decoder.sv @@
// Top level of the TLV stream decoder: config registers, parser and result register.
`timescale 1ns / 1ps
`default_nettype none

// A result appears on the output channel in the cycle after its byte request is taken.
// Throughput: one byte per cycle while the sink takes each result; set by the single result register, which takes a
//   new request in the same cycle the sink takes the old one.
// Bytes that give no result (header bytes mid-entry) still need room in the result register to be taken.
// Reset (rst, synchronous, active high): parser back to header byte 0, result
//   register empty, type codes back to their defaults.

module tlv_stream_decoder
  import tsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  tsd_in_if.sink     in_stream,
  tsd_out_if.source  result,
  tsd_cfg_if.sink    cfg
);

  codes_t  codes;
  result_t parsed;
  logic    has_result;
  logic    space;
  logic    fire;

  // Type codes; the user must write them only while the stream is idle, the block does not enforce it
  tsd_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .codes (codes)
  );

  // Byte request taken whenever the result register has room
  assign in_stream.ready = space;
  assign fire            = in_stream.valid && space;

  // Header collection, value pass-through and entry report
  tsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_byte     (in_stream.in_byte),
    .buffer_last (in_stream.buffer_last),
    .codes       (codes),
    .has_result  (has_result),
    .result      (parsed)
  );

  // Only bytes that give a result (value bytes and entry reports) load the register
  tsd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && has_result),
    .result_in (parsed),
    .space     (space),
    .result    (result)
  );

endmodule

`default_nettype wire
